@@ hdl/recursive_chirp_phasor_generator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the recursive chirp phasor generator
// Each macro expands to one labelled concurrent assertion on the rising clock.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_CHIRP_PHASOR_GENERATOR_MACROS_SVH
`define RECURSIVE_CHIRP_PHASOR_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpg_pkg
// Types and constants shared by the recursive chirp phasor generator.
// ----------------------------------------------------------------------------
package rcpg_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FRAC_W     = SAMPLE_W - 1;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int SPI_W      = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;

   localparam logic signed [SAMPLE_W-1:0] VAL_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] VAL_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SPI_W-1:0]           SPI_RESET = SPI_W'(256);

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES_PER_INTERVAL = 1'b0;

   // Item function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] start_re;
      logic signed [SAMPLE_W-1:0] start_im;
      logic signed [SAMPLE_W-1:0] base_rot_re;
      logic signed [SAMPLE_W-1:0] base_rot_im;
      logic signed [SAMPLE_W-1:0] quad_rot_re;
      logic signed [SAMPLE_W-1:0] quad_rot_im;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic                       last_in_interval;
   } rsp_payload_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL_A = 7'b0000010,
      ST_RND_A = 7'b0000100,
      ST_MUL_B = 7'b0001000,
      ST_RND_B = 7'b0010000,
      ST_MUL_C = 7'b0100000,
      ST_RND_C = 7'b1000000
   } state_type;

endpackage

@@ hdl/recursive_chirp_phasor_generator.sv @@
// ----------------------------------------------------------------------------
// recursive_chirp_phasor_generator
// Quadratic-phase phasor generator built on one shared complex multiplier.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Carries
//   req_      in         valid / ready      load or step item
//   rsp_      out        valid / ready      one sample per step item
//   csr_      in         APB write / read   samples_per_interval
//
// A load item completes on acceptance. A step item runs through acceptance,
// then three complex multiplies through the one shared multiplier unit, each
// a product state followed by a round-and-saturate state.
// The sample is registered at acceptance. A new item is taken only once that
// sample has left, or leaves in the same cycle, so a stalled result channel
// holds off the input. Reset is synchronous and restores the unit phasors,
// a zero start phasor and an interval of 256.
// ----------------------------------------------------------------------------
`include "recursive_chirp_phasor_generator_macros.svh"

module recursive_chirp_phasor_generator #(
   parameter int MAX_INTERVAL = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rcpg_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rcpg_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rcpg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rcpg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rcpg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import rcpg_pkg::*;

   localparam int IDX_W  = (MAX_INTERVAL > 2) ? $clog2(MAX_INTERVAL) : 1;
   localparam int MAXL_W = $clog2(MAX_INTERVAL + 1);
   localparam int LEN_W  = (MAXL_W > SPI_W) ? MAXL_W : SPI_W;
   localparam int Q_W    = SUM_W - FRAC_W;

   state_type state_ff, state_in;

   logic [SPI_W-1:0] spi_ff, spi_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic signed [SAMPLE_W-1:0] phasor_re_ff, phasor_re_in, phasor_im_ff, phasor_im_in;
   logic signed [SAMPLE_W-1:0] fixed_re_ff, fixed_re_in, fixed_im_ff, fixed_im_in;
   logic signed [SAMPLE_W-1:0] run_re_ff, run_re_in, run_im_ff, run_im_in;
   logic signed [SAMPLE_W-1:0] step_re_ff, step_re_in, step_im_ff, step_im_in;
   logic signed [SAMPLE_W-1:0] t_re_ff, t_re_in, t_im_ff, t_im_in;

   // Product registers of the shared multiplier
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;

   logic signed [SAMPLE_W-1:0] op_ar, op_ai, op_br, op_bi;
   logic signed [SAMPLE_W-1:0] rnd_re, rnd_im;
   logic [LEN_W-1:0]           len_eff, idx_next;
   logic                       last_flag;
   logic                       req_fire, cfg_write;

   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [SUM_W-1:0] sum
   );
      logic signed [SUM_W-1:0] biased;
      logic signed [Q_W-1:0]   q;
      begin
         biased = sum + SUM_W'(1 <<< (FRAC_W - 1));
         q      = Q_W'(biased >>> FRAC_W);
         if (q > Q_W'(VAL_MAX)) begin
            round_sat = VAL_MAX;
         end else if (q < Q_W'(VAL_MIN)) begin
            round_sat = VAL_MIN;
         end else begin
            round_sat = q[SAMPLE_W-1:0];
         end
      end
   endfunction

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_SAMPLES_PER_INTERVAL);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_SAMPLES_PER_INTERVAL) ?
                       CSR_DATA_W'(spi_ff) : '0;

   // Interval length, with zero acting as one and a cap at the maximum.
   always_comb begin
      if (spi_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (LEN_W'(spi_ff) > LEN_W'(MAX_INTERVAL)) begin
         len_eff = LEN_W'(MAX_INTERVAL);
      end else begin
         len_eff = LEN_W'(spi_ff);
      end
      idx_next  = LEN_W'(idx_ff) + LEN_W'(1);
      last_flag = (idx_next >= len_eff);
   end

   // Operand selection for the shared complex multiplier
   always_comb begin
      unique case (state_ff)
         ST_MUL_B: begin
            op_ar = t_re_ff;   op_ai = t_im_ff;
            op_br = run_re_ff; op_bi = run_im_ff;
         end
         ST_MUL_C: begin
            op_ar = run_re_ff;  op_ai = run_im_ff;
            op_br = step_re_ff; op_bi = step_im_ff;
         end
         default: begin
            op_ar = phasor_re_ff; op_ai = phasor_im_ff;
            op_br = fixed_re_ff;  op_bi = fixed_im_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= op_ar * op_br;
      p_ii_ff <= op_ai * op_bi;
      p_ri_ff <= op_ar * op_bi;
      p_ir_ff <= op_ai * op_br;
   end

   assign rnd_re = round_sat(SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff));
   assign rnd_im = round_sat(SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff));

   always_comb begin
      state_in       = state_ff;
      spi_in         = cfg_write ? csr_pwdata[SPI_W-1:0] : spi_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      phasor_re_in   = phasor_re_ff;
      phasor_im_in   = phasor_im_ff;
      fixed_re_in    = fixed_re_ff;
      fixed_im_in    = fixed_im_ff;
      run_re_in      = run_re_ff;
      run_im_in      = run_im_ff;
      step_re_in     = step_re_ff;
      step_im_in     = step_im_ff;
      t_re_in        = t_re_ff;
      t_im_in        = t_im_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.func == FUNC_LOAD) begin
                  phasor_re_in = req_payload.start_re;
                  phasor_im_in = req_payload.start_im;
                  fixed_re_in  = req_payload.base_rot_re;
                  fixed_im_in  = req_payload.base_rot_im;
                  step_re_in   = req_payload.quad_rot_re;
                  step_im_in   = req_payload.quad_rot_im;
                  run_re_in    = req_payload.quad_rot_re;
                  run_im_in    = req_payload.quad_rot_im;
                  idx_in       = '0;
               end else begin
                  rsp_valid_in                    = 1'b1;
                  rsp_payload_in.sample_re        = phasor_re_ff;
                  rsp_payload_in.sample_im        = phasor_im_ff;
                  rsp_payload_in.last_in_interval = last_flag;
                  idx_in   = last_flag ? '0 : idx_next[IDX_W-1:0];
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: state_in = ST_RND_A;
         ST_RND_A: begin
            t_re_in  = rnd_re;
            t_im_in  = rnd_im;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: state_in = ST_RND_B;
         ST_RND_B: begin
            phasor_re_in = rnd_re;
            phasor_im_in = rnd_im;
            state_in     = ST_MUL_C;
         end
         ST_MUL_C: state_in = ST_RND_C;
         ST_RND_C: begin
            // The running rotation is only replaced once the phasor has used it.
            run_re_in = rnd_re;
            run_im_in = rnd_im;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spi_ff       <= SPI_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         phasor_re_ff <= '0;
         phasor_im_ff <= '0;
         fixed_re_ff  <= VAL_MAX;
         fixed_im_ff  <= '0;
         run_re_ff    <= VAL_MAX;
         run_im_ff    <= '0;
         step_re_ff   <= VAL_MAX;
         step_im_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         spi_ff       <= spi_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         phasor_re_ff <= phasor_re_in;
         phasor_im_ff <= phasor_im_in;
         fixed_re_ff  <= fixed_re_in;
         fixed_im_ff  <= fixed_im_in;
         run_re_ff    <= run_re_in;
         run_im_ff    <= run_im_in;
         step_re_ff   <= step_re_in;
         step_im_ff   <= step_im_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      t_re_ff        <= t_re_in;
      t_im_ff        <= t_im_in;
   end

   `RCPG_ASSERT_NEXT(a_step_starts, clock, reset,
      req_fire && req_payload.func == FUNC_STEP,
      state_ff == ST_MUL_A && rsp_valid_ff,
      "step item did not start the multiply sequence")
   `RCPG_ASSERT_NEXT(a_load_state, clock, reset,
      req_fire && req_payload.func == FUNC_LOAD,
      run_re_ff == step_re_ff && run_im_ff == step_im_ff && idx_ff == '0,
      "load item left inconsistent rotation or count")
   `RCPG_ASSERT_NEXT(a_last_wraps, clock, reset,
      req_fire && req_payload.func == FUNC_STEP && last_flag,
      idx_ff == '0,
      "sample count did not wrap after the last sample")
   `RCPG_ASSERT_NEXT(a_seq_ends, clock, reset,
      state_ff == ST_RND_C,
      state_ff == ST_IDLE,
      "multiply sequence did not return to idle")

endmodule
